[sv/sptw_pkg.sv]
// ----------------------------------------------------------------------------
// sptw_pkg: shared types, constants and functions
// Holds the register map, the configuration bundle, the CORDIC state word
// and the arctangent table used by the beam-to-point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sptw_pkg;

	// Number of beams a scan may hold; larger indexes are dropped.
	localparam int MAX_BEAMS = 4096;

	// CORDIC layout: sixteen rotations, two per pipeline stage.
	localparam int ITERS           = 16;
	localparam int ITERS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = ITERS / ITERS_PER_STAGE;

	// Start vector length: CORDIC gain compensation 0.60725 in Q1.15.
	localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_RANGE_FLOOR   = 3'd0,
		REG_RANGE_CEILING = 3'd1,
		REG_START_ANGLE   = 3'd2,
		REG_ANGLE_STEP    = 3'd3,
		REG_POSE_X        = 3'd4,
		REG_POSE_Y        = 3'd5,
		REG_POSE_HEADING  = 3'd6
	} reg_idx_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic        [15:0] range_floor;
		logic        [15:0] range_ceiling;
		logic        [15:0] start_angle;
		logic        [15:0] angle_step;
		logic signed [23:0] pose_x;
		logic signed [23:0] pose_y;
		logic        [15:0] pose_heading;
	} cfg_t;

	// CORDIC vector and residual angle (turn units of 2^-32).
	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [31:0] z;
	} rot_t;

	// Per-beam data that rides along with the rotation.
	typedef struct packed {
		logic [15:0] rng;
		logic [11:0] beam;
		logic        flip;
	} tag_t;

	// Arctangent of 2^-i in turn units of 2^-32.
	function automatic logic signed [31:0] atan_lut(input logic [3:0] i);
		logic signed [31:0] a;
		case (i)
			4'd0:    a = 32'sd536870912;
			4'd1:    a = 32'sd316933406;
			4'd2:    a = 32'sd167458907;
			4'd3:    a = 32'sd85004756;
			4'd4:    a = 32'sd42667331;
			4'd5:    a = 32'sd21354465;
			4'd6:    a = 32'sd10680862;
			4'd7:    a = 32'sd5340757;
			4'd8:    a = 32'sd2670675;
			4'd9:    a = 32'sd1335343;
			4'd10:   a = 32'sd667544;
			4'd11:   a = 32'sd333772;
			4'd12:   a = 32'sd166886;
			4'd13:   a = 32'sd83443;
			4'd14:   a = 32'sd41721;
			default: a = 32'sd20860;
		endcase
		return a;
	endfunction

	// One rotation-mode CORDIC step with shift i.
	function automatic rot_t rot_step(input rot_t r, input logic [3:0] i);
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [31:0] z;
		logic signed [31:0] a;
		rot_t o;
		x = r.x;
		y = r.y;
		z = r.z;
		a = atan_lut(i);
		if (!z[31]) begin
			o.x = x - (y >>> i);
			o.y = y + (x >>> i);
			o.z = z - a;
		end else begin
			o.x = x + (y >>> i);
			o.y = y - (x >>> i);
			o.z = z + a;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

[sv/sptw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sptw_cfg_regs: configuration registers
// APB-style register file holding range window, scan angles and robot pose.
// ----------------------------------------------------------------------------
`default_nettype none

module sptw_cfg_regs
	import sptw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic     wr_en;
	reg_idx_t idx;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.range_floor   <= 16'd0;
			cfg.range_ceiling <= 16'hFFFF;
			cfg.start_angle   <= 16'd0;
			cfg.angle_step    <= 16'd0;
			cfg.pose_x        <= 24'sd0;
			cfg.pose_y        <= 24'sd0;
			cfg.pose_heading  <= 16'd0;
		end else if (wr_en) begin
			case (idx)
				REG_RANGE_FLOOR:   cfg.range_floor   <= pwdata[15:0];
				REG_RANGE_CEILING: cfg.range_ceiling <= pwdata[15:0];
				REG_START_ANGLE:   cfg.start_angle   <= pwdata[15:0];
				REG_ANGLE_STEP:    cfg.angle_step    <= pwdata[15:0];
				REG_POSE_X:        cfg.pose_x        <= pwdata[23:0];
				REG_POSE_Y:        cfg.pose_y        <= pwdata[23:0];
				REG_POSE_HEADING:  cfg.pose_heading  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux; unused addresses read as zero.
	always_comb begin
		case (idx)
			REG_RANGE_FLOOR:   prdata = {16'd0, cfg.range_floor};
			REG_RANGE_CEILING: prdata = {16'd0, cfg.range_ceiling};
			REG_START_ANGLE:   prdata = {16'd0, cfg.start_angle};
			REG_ANGLE_STEP:    prdata = {16'd0, cfg.angle_step};
			REG_POSE_X:        prdata = {8'd0, cfg.pose_x};
			REG_POSE_Y:        prdata = {8'd0, cfg.pose_y};
			REG_POSE_HEADING:  prdata = {16'd0, cfg.pose_heading};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[sv/sptw_angle.sv]
// ----------------------------------------------------------------------------
// sptw_angle: beam filter and angle front end
// Drops beams outside the range window, forms the world beam angle and folds
// it into the CORDIC convergence range, producing the start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module sptw_angle
	import sptw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  cfg_t             cfg,
	input  wire logic        beam_valid,
	input  wire logic [15:0] beam_range,
	input  wire logic        no_return,
	input  wire logic [11:0] beam_index,
	output logic             v_s1,
	output logic             v_s2,
	output rot_t             rot_s2,
	output tag_t             tag_s2
);

	logic        keep;
	logic [27:0] prod_full;
	logic [15:0] step_s1;
	logic [15:0] rng_s1;
	logic [11:0] beam_s1;
	logic [15:0] ang;
	logic        flip;
	logic [15:0] ang_fold;

	// Stage 1: range window check and index times step.
	assign keep = !no_return
		&& (beam_range >= cfg.range_floor)
		&& (beam_range <= cfg.range_ceiling)
		&& (32'(beam_index) < MAX_BEAMS);
	assign prod_full = 28'(beam_index) * 28'(cfg.angle_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= beam_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_s1 <= prod_full[15:0];
			rng_s1  <= beam_range;
			beam_s1 <= beam_index;
		end
	end

	// Stage 2: world angle, fold the left half plane by half a turn.
	assign ang      = cfg.start_angle + step_s1 + cfg.pose_heading;
	assign flip     = ang[15] ^ ang[14];
	assign ang_fold = flip ? (ang ^ 16'h8000) : ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rot_s2.x    <= CORDIC_X0;
			rot_s2.y    <= 18'sd0;
			rot_s2.z    <= {ang_fold, 16'h0000};
			tag_s2.rng  <= rng_s1;
			tag_s2.beam <= beam_s1;
			tag_s2.flip <= flip;
		end
	end

endmodule

`default_nettype wire

[sv/sptw_cordic.sv]
// ----------------------------------------------------------------------------
// sptw_cordic: pipelined rotation CORDIC
// Sixteen rotations spread over eight register stages, two per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sptw_cordic
	import sptw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic v_in,
	input  rot_t      rot_in,
	input  tag_t      tag_in,
	output logic      v_out,
	output rot_t      rot_out,
	output tag_t      tag_out
);

	// Entry 0 is the stage input; entry g+1 is the register after stage g.
	logic stage_v_s   [CORDIC_STAGES+1];
	rot_t stage_rot_s [CORDIC_STAGES+1];
	tag_t stage_tag_s [CORDIC_STAGES+1];

	assign stage_v_s[0]   = v_in;
	assign stage_rot_s[0] = rot_in;
	assign stage_tag_s[0] = tag_in;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		rot_t nxt;

		// Two dependent rotations in this stage.
		always_comb begin
			nxt = stage_rot_s[g];
			for (int j = 0; j < ITERS_PER_STAGE; j++) begin
				nxt = rot_step(nxt, 4'(ITERS_PER_STAGE * g + j));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_v_s[g+1] <= 1'b0;
			end else if (adv) begin
				stage_v_s[g+1] <= stage_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_rot_s[g+1] <= nxt;
				stage_tag_s[g+1] <= stage_tag_s[g];
			end
		end
	end

	assign v_out   = stage_v_s[CORDIC_STAGES];
	assign rot_out = stage_rot_s[CORDIC_STAGES];
	assign tag_out = stage_tag_s[CORDIC_STAGES];

endmodule

`default_nettype wire

[sv/sptw_scale.sv]
// ----------------------------------------------------------------------------
// sptw_scale: range scaling and pose offset
// Unfolds and saturates cos/sin, multiplies by the range, rounds to whole
// millimetres, adds the robot pose and saturates to 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sptw_scale
	import sptw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  cfg_t             cfg,
	input  wire logic        v_in,
	input  rot_t             rot_in,
	input  tag_t             tag_in,
	output logic             point_valid,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic [11:0]      point_beam
);

	logic signed [17:0] xu;
	logic signed [17:0] yu;
	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;

	logic               v_s1;
	logic signed [15:0] cos_s1;
	logic signed [15:0] sin_s1;
	logic [15:0]        rng_s1;
	logic [11:0]        beam_s1;

	logic               v_s2;
	logic signed [32:0] px_s2;
	logic signed [32:0] py_s2;
	logic [11:0]        beam_s2;

	logic signed [32:0] px_rnd;
	logic signed [32:0] py_rnd;
	logic signed [25:0] sum_x;
	logic signed [25:0] sum_y;
	logic signed [23:0] sat_x;
	logic signed [23:0] sat_y;

	// Saturate an 18-bit value to Q1.15.
	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Saturate a 26-bit sum to 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > 26'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -26'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// Stage 1: undo the half-turn fold and saturate.
	assign xu    = tag_in.flip ? -rot_in.x : rot_in.x;
	assign yu    = tag_in.flip ? -rot_in.y : rot_in.y;
	assign cos_q = sat16(xu);
	assign sin_q = sat16(yu);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			point_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			point_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1  <= cos_q;
			sin_s1  <= sin_q;
			rng_s1  <= tag_in.rng;
			beam_s1 <= tag_in.beam;
		end
	end

	// Stage 2: range times cos and sin.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2   <= 33'($signed({1'b0, rng_s1})) * 33'(cos_s1);
			py_s2   <= 33'($signed({1'b0, rng_s1})) * 33'(sin_s1);
			beam_s2 <= beam_s1;
		end
	end

	// Stage 3: round half up, add the pose, saturate.
	assign px_rnd = (px_s2 + 33'sd16384) >>> 15;
	assign py_rnd = (py_s2 + 33'sd16384) >>> 15;
	assign sum_x  = 26'($signed(cfg.pose_x)) + 26'($signed(px_rnd[17:0]));
	assign sum_y  = 26'($signed(cfg.pose_y)) + 26'($signed(py_rnd[17:0]));
	assign sat_x  = sat24(sum_x);
	assign sat_y  = sat24(sum_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			point_x    <= sat_x;
			point_y    <= sat_y;
			point_beam <= beam_s2;
		end
	end

endmodule

`default_nettype wire

[sv/scan_polar_to_world_points.sv]
// ----------------------------------------------------------------------------
// scan_polar_to_world_points: lidar beam to world obstacle point
// Top level: configuration port, angle front end, CORDIC and scaling stages.
// ----------------------------------------------------------------------------
// The block takes one beam word per clock while beam_stall is low and
// returns its world-frame point through 2 front-end stages, 8 CORDIC stages
// of two rotations each and 3 scaling stages. Beams with no return or a
// range outside the window are dropped at the first stage and give no point
// word. The whole pipeline moves as one: while a finished point word is held
// by point_stall, every stage holds and beam_stall is raised. Configuration
// is sampled live, so write it only while no beam is in flight.
`default_nettype none

module scan_polar_to_world_points
	import sptw_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	input  wire logic          beam_valid,
	output logic               beam_stall,
	input  wire logic [15:0]   beam_range,
	input  wire logic          no_return,
	input  wire logic [11:0]   beam_index,
	output logic               point_valid,
	input  wire logic          point_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic [11:0]        point_beam
);

	cfg_t cfg;
	logic adv;
	logic v_s1;
	logic v_s2;
	rot_t rot_s2;
	tag_t tag_s2;
	logic v_cor;
	rot_t rot_cor;
	tag_t tag_cor;

	// The pipeline advances unless the output word is held.
	assign adv        = !(point_valid && point_stall);
	assign beam_stall = !adv;

	sptw_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sptw_angle u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cfg        (cfg),
		.beam_valid (beam_valid),
		.beam_range (beam_range),
		.no_return  (no_return),
		.beam_index (beam_index),
		.v_s1       (v_s1),
		.v_s2       (v_s2),
		.rot_s2     (rot_s2),
		.tag_s2     (tag_s2)
	);

	sptw_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_s2),
		.rot_in  (rot_s2),
		.tag_in  (tag_s2),
		.v_out   (v_cor),
		.rot_out (rot_cor),
		.tag_out (tag_cor)
	);

	sptw_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg),
		.v_in        (v_cor),
		.rot_in      (rot_cor),
		.tag_in      (tag_cor),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_beam  (point_beam)
	);

	// A beam without a return never enters the first stage.
	a_drop_no_return: assert property (@(posedge clk) disable iff (!arst_n)
		beam_valid && !beam_stall && no_return |=> !v_s1)
		else $error("beam without return entered the pipeline");

	// After all rotations the residual angle is close to zero.
	a_cordic_converged: assert property (@(posedge clk) disable iff (!arst_n)
		v_cor |-> (rot_cor.z < 32'sd65536) && (rot_cor.z > -32'sd65536))
		else $error("CORDIC residual angle did not converge");

	// A held pipeline keeps its first-stage valid bit.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v_s1 == $past(v_s1))
		else $error("first stage changed while the pipeline was held");

endmodule

`default_nettype wire
